FILE: rtl/core/gpio_pei_pkg.sv
// types, constants and codes shared by the gpio port edge interrupt block
`timescale 1ns / 1ps

package gpio_pei_pkg;

  // port number this instance answers to in the channel selectors
  localparam logic [3:0] PORT_INDEX = 4'h0;
  // pin code that selects the whole port
  localparam logic [3:0] PIN_CODE_PORT = 4'h8;

  typedef enum logic [2:0] {
    CMD_PINS      = 3'd0,
    CMD_LATCH     = 3'd1,
    CMD_DIRECTION = 3'd2,
    CMD_SET_EN    = 3'd3,
    CMD_CLR_STAT  = 3'd4,
    CMD_REFRESH   = 3'd5
  } gpio_pei_cmd_t;

  // edge mode codes, low three bits of each pin nibble
  localparam logic [2:0] MODE_FALL = 3'd0;
  localparam logic [2:0] MODE_RISE = 3'd1;
  localparam logic [2:0] MODE_BOTH = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_PULL_CONTROL   = 2'd0;
  localparam logic [1:0] REG_EDGE_MODES     = 2'd1;
  localparam logic [1:0] REG_CHANNEL_SELECT = 2'd2;
  localparam logic [1:0] REG_CHANNEL_EDGE   = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] pin_values;
    logic [7:0] pin_driven;
    logic [7:0] write_value;
  } gpio_pei_in_t;

  typedef struct packed {
    logic [7:0] port_level;
    logic [7:0] output_drive;
    logic [7:0] direction_readback;
    logic [7:0] int_status;
    logic [7:0] int_enable;
    logic [7:0] channel_irq;
  } gpio_pei_out_t;

  typedef struct packed {
    logic [15:0] pull_control;
    logic [31:0] edge_modes;
    logic [63:0] channel_select;
    logic [15:0] channel_edge_enable;
  } gpio_pei_cfg_t;

  typedef struct packed {
    logic [7:0] out_latch;
    logic [7:0] direction;
    logic [7:0] last_pins;
    logic [7:0] ext_pins;
    logic [7:0] ext_driven;
    logic [7:0] irq_enable;
    logic [7:0] irq_status;
    logic [7:0] held_level;
  } gpio_pei_state_t;

endpackage

FILE: rtl/core/gpio_pei_cfg.sv
// configuration register file of the gpio port edge interrupt block
`timescale 1ns / 1ps

module gpio_pei_cfg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  output gpio_pei_pkg::gpio_pei_cfg_t cfg
);
  import gpio_pei_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULL_CONTROL:   cfg.pull_control        <= cfg_data[15:0];
        REG_EDGE_MODES:     cfg.edge_modes          <= cfg_data[31:0];
        REG_CHANNEL_SELECT: cfg.channel_select      <= cfg_data;
        REG_CHANNEL_EDGE:   cfg.channel_edge_enable <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/gpio_pei_core.sv
// command decode, input resolve and edge detect for one port command
`timescale 1ns / 1ps

module gpio_pei_core (
  input  gpio_pei_pkg::gpio_pei_in_t    item,
  input  gpio_pei_pkg::gpio_pei_cfg_t   cfg,
  input  gpio_pei_pkg::gpio_pei_state_t state,
  output gpio_pei_pkg::gpio_pei_state_t state_next,
  output gpio_pei_pkg::gpio_pei_out_t   result
);
  import gpio_pei_pkg::*;

  logic            go;
  gpio_pei_state_t upd;
  logic [7:0]      c0;
  logic [7:0]      c1;
  logic [7:0]      eff;
  logic [7:0]      diff;
  logic [7:0]      rise_edge;
  logic [7:0]      fall_edge;
  logic [7:0]      rise_m;
  logic [7:0]      fall_m;
  logic [7:0]      hit;
  logic [7:0]      port_sel;
  logic [7:0]      pin_irq;
  logic            port_wide;
  logic [7:0]      sel;

  // register writes by command
  always_comb begin
    upd = state;
    go  = 1'b1;
    case (item.command)
      CMD_PINS: begin
        upd.ext_pins   = item.pin_values;
        upd.ext_driven = item.pin_driven;
      end
      CMD_LATCH:     upd.out_latch  = item.write_value;
      CMD_DIRECTION: upd.direction  = item.write_value;
      CMD_SET_EN:    upd.irq_enable = state.irq_enable | item.write_value;
      CMD_CLR_STAT:  upd.irq_status = state.irq_status & ~item.write_value;
      CMD_REFRESH:   go = item.write_value[0];
      default:       go = 1'b0;
    endcase
  end

  // effective input with pulls on floating pins
  assign c0        = cfg.pull_control[7:0];
  assign c1        = cfg.pull_control[15:8];
  assign eff       = (upd.ext_pins & upd.ext_driven) | (c1 & (c0 ^ c1) & ~upd.ext_driven);
  assign diff      = eff ^ state.last_pins;
  assign rise_edge = eff & diff;
  assign fall_edge = state.last_pins & diff;

  always_comb begin
    rise_m = '0;
    fall_m = '0;
    for (int n = 0; n < 8; n++) begin
      case (cfg.edge_modes[4*n +: 3])
        MODE_FALL: fall_m[n] = 1'b1;
        MODE_RISE: rise_m[n] = 1'b1;
        MODE_BOTH: begin
          rise_m[n] = 1'b1;
          fall_m[n] = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // channel matching, port-wide and single pin
  always_comb begin
    port_sel = '0;
    pin_irq  = '0;
    for (int j = 0; j < 8; j++) begin
      sel = cfg.channel_select[8*j +: 8];
      port_sel[j] = (sel[7:4] == PORT_INDEX) && (sel[3:0] == PIN_CODE_PORT);
      if ((sel[7:4] == PORT_INDEX) && !sel[3]) begin
        pin_irq[j] = (cfg.channel_edge_enable[8+j] && rise_edge[sel[2:0]])
                  || (cfg.channel_edge_enable[j]   && fall_edge[sel[2:0]]);
      end
    end
  end

  assign port_wide = |port_sel;
  assign hit       = ((rise_edge & rise_m) | (fall_edge & fall_m)) & upd.irq_enable;

  always_comb begin
    state_next         = upd;
    result.channel_irq = '0;
    if (go) begin
      state_next.held_level = (upd.out_latch & ~upd.direction) | (eff & upd.direction);
      state_next.last_pins  = eff & upd.direction;
      if (port_wide) begin
        if (hit != '0) begin
          state_next.irq_status = hit;
          state_next.irq_enable = '0;
          result.channel_irq    = port_sel;
        end
      end else begin
        result.channel_irq = pin_irq;
      end
    end
    result.port_level         = state_next.held_level;
    result.output_drive       = upd.out_latch & ~upd.direction;
    result.direction_readback = upd.direction;
    result.int_status         = state_next.irq_status;
    result.int_enable         = state_next.irq_enable;
  end

endmodule

FILE: rtl/core/gpio_port_edge_interrupt_unit.sv
// top level of the 8-pin gpio port with edge interrupts
`timescale 1ns / 1ps
// path: a command is held in the input register, and its result is loaded into the result register
//   and transfers out from there when out_ready is high
// throughput: one command per cycle while the result channel does not stall, set by the state update in gpio_pei_core
// the result register takes a new result while the old one leaves, so stalls only back up
// reset (rst, synchronous): clears port state, configuration and both valid flags

module gpio_port_edge_interrupt_unit (
  input  logic                         clk,
  input  logic                         rst,
  // command channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gpio_pei_pkg::gpio_pei_in_t   in_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output gpio_pei_pkg::gpio_pei_out_t  out_data,
  // configuration writes
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [63:0]                  cfg_data
);
  import gpio_pei_pkg::*;

  gpio_pei_cfg_t   cfg;
  gpio_pei_state_t state;
  gpio_pei_state_t state_next;
  gpio_pei_in_t    item;
  gpio_pei_out_t   result;
  logic            item_valid;
  logic            advance;

  // result register can load when empty or when its transfer happens this cycle
  assign advance  = item_valid && (!out_valid || out_ready);
  // input register frees up whenever its item moves on
  assign in_ready = !item_valid || advance;

  gpio_pei_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register, payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  gpio_pei_core u_core (
    .item       (item),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  // port state commits exactly once per command, when it moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

FILE: rtl/core/gpio_pei_checker.sv
// port-level checker for the gpio port edge interrupt block, with its bind
`timescale 1ns / 1ps

module gpio_pei_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input gpio_pei_pkg::gpio_pei_out_t out_data
);
  import gpio_pei_pkg::*;

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // pins set to input never drive
  a_drive_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.output_drive & out_data.direction_readback) == 8'h00)
    else $error("drive on an input pin");

  // a ready output side always frees the input side
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output ready");

endmodule

bind gpio_port_edge_interrupt_unit gpio_pei_checker u_gpio_pei_checker (.*);
